// ----- hw/rtl/fseg_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fseg_pkg
// Shared types and constants of the first-fit segment allocator.
// ---------------------------------------------------------------------------
package fseg_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int SLOT_W       = $clog2(MAX_SEGMENTS);
  localparam int SIZE_W       = 34;
  localparam int POOL_W       = 54;
  localparam logic [POOL_W-1:0] LIMIT32 = POOL_W'(64'hFFFF_FFFF);

  // segment flag bit positions
  localparam int FL_VALID  = 0;
  localparam int FL_ACTIVE = 1;
  localparam int FL_BUSY   = 2;
  localparam int FL_KILL   = 3;
  localparam int FL_FIRST  = 4;
  localparam int FL_LAST   = 5;

  // request modes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_ATTACH  = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_DEFER = 3'd1;
  localparam logic [2:0] STAT_FULL  = 3'd2;
  localparam logic [2:0] STAT_BADH  = 3'd3;
  localparam logic [2:0] STAT_OVF   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_PAGE_SHIFT = 2'd0;
  localparam logic [1:0] CFG_INIT_PAGES = 2'd1;

  typedef logic [5:0] flags_t;

  typedef struct packed {
    logic [31:0]       offset;
    logic [31:0]       length;
    logic [SLOT_W-1:0] lower;
    logic [SLOT_W-1:0] higher;
  } seg_t;

  typedef struct packed {
    logic off;
    logic len;
    logic lo;
    logic hi;
  } wmask_t;

  typedef struct packed {
    logic              we;
    wmask_t            mask;
    logic [SLOT_W-1:0] waddr;
    seg_t              wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] offset;
    logic [16:0] stride;
    logic [31:0] pool;
    logic        resized;
  } res_t;

endpackage

// ----- hw/rtl/fseg_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fseg_mem
// Segment table memory: one masked write port, one registered read port.
// ---------------------------------------------------------------------------
module fseg_mem (
  input  logic               clk_i,
  input  fseg_pkg::mem_req_t req_i,
  output fseg_pkg::seg_t     rdata_o
);
  import fseg_pkg::*;

  seg_t mem_q [MAX_SEGMENTS];
  seg_t rdata_q;

  // field-masked write
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      if (req_i.mask.off) mem_q[req_i.waddr].offset <= req_i.wdata.offset;
      if (req_i.mask.len) mem_q[req_i.waddr].length <= req_i.wdata.length;
      if (req_i.mask.lo)  mem_q[req_i.waddr].lower  <= req_i.wdata.lower;
      if (req_i.mask.hi)  mem_q[req_i.waddr].higher <= req_i.wdata.higher;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fseg_size.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fseg_size
// Two-stage request sizing: 4*width*height rounded up to a whole page.
// ---------------------------------------------------------------------------
module fseg_size (
  input  logic                        clk_i,
  input  logic [14:0]                 width_i,
  input  logic [14:0]                 height_i,
  input  logic [4:0]                  page_shift_i,
  output logic [fseg_pkg::SIZE_W-1:0] size_o
);
  import fseg_pkg::*;

  logic [29:0]       prod_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] page;
  logic [SIZE_W-1:0] mask;
  logic [SIZE_W-1:0] rnd;

  // stage one: pixel count
  always_ff @(posedge clk_i) begin
    prod_q <= width_i * height_i;
  end

  // stage two: bytes rounded to a page, zero takes one page
  always_comb begin
    page = SIZE_W'(1) << page_shift_i;
    mask = page - SIZE_W'(1);
    rnd  = ({2'b00, prod_q, 2'b00} + mask) & ~mask;
  end

  always_ff @(posedge clk_i) begin
    size_q <= (rnd == '0) ? page : rnd;
  end

  assign size_o = size_q;

endmodule

// ----- hw/rtl/fseg_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fseg_ctrl
// Sequencer: first-fit search, split, growth and coalescing over the
// segment table, with flags, top slot and grown bytes in flip-flops.
// ---------------------------------------------------------------------------
module fseg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          mode_i,
  input  logic [14:0]         width_i,
  input  logic [14:0]         height_i,
  input  logic [3:0]          handle_i,
  input  logic [4:0]          page_shift_i,
  input  logic [20:0]         init_pages_i,
  input  logic                out_free_i,
  output logic                idle_o,
  output logic                done_o,
  output fseg_pkg::res_t      res_o
);
  import fseg_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL    = 5'd1;
  localparam logic [4:0] S_RND    = 5'd2;
  localparam logic [4:0] S_ASTART = 5'd3;
  localparam logic [4:0] S_SRCH   = 5'd4;
  localparam logic [4:0] S_SPLIT  = 5'd5;
  localparam logic [4:0] S_SPLIT2 = 5'd6;
  localparam logic [4:0] S_SPLIT3 = 5'd7;
  localparam logic [4:0] S_NOFIT  = 5'd8;
  localparam logic [4:0] S_GROW   = 5'd9;
  localparam logic [4:0] S_APPEND = 5'd10;
  localparam logic [4:0] S_APP2   = 5'd11;
  localparam logic [4:0] S_EMPTY  = 5'd12;
  localparam logic [4:0] S_CHK    = 5'd13;
  localparam logic [4:0] S_RS     = 5'd14;
  localparam logic [4:0] S_RH     = 5'd15;
  localparam logic [4:0] S_RH2    = 5'd16;
  localparam logic [4:0] S_RL0    = 5'd17;
  localparam logic [4:0] S_RL     = 5'd18;
  localparam logic [4:0] S_RL2    = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [4:0]        state_q, state_d;
  logic [1:0]        mode_q, mode_d;
  logic [14:0]       w_q, w_d;
  logic [14:0]       h_q, h_d;
  logic [3:0]        hd_q, hd_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  seg_t              cur_q, cur_d;
  logic [SLOT_W-1:0] new_slot_q, new_slot_d;
  logic [SLOT_W-1:0] aux_slot_q, aux_slot_d;
  logic [SIZE_W-1:0] delta_q, delta_d;
  logic [31:0]       app_off_q, app_off_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  res_t              res_q, res_d;
  flags_t            flags_q [MAX_SEGMENTS];
  flags_t            flags_d [MAX_SEGMENTS];
  logic [SLOT_W-1:0] top_q, top_d;
  logic [31:0]       grown_q, grown_d;

  mem_req_t          mreq;
  seg_t              rdata;
  logic [SIZE_W-1:0] size;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              any_valid;
  logic [POOL_W-1:0] pool_sum;
  logic              ovf_size;
  logic              ovf_delta;
  logic [SLOT_W-1:0] hslot;
  logic              fit;

  fseg_size u_size (
    .clk_i        (clk_i),
    .width_i      (w_q),
    .height_i     (h_q),
    .page_shift_i (page_shift_i),
    .size_o       (size)
  );

  fseg_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // lowest free slot and occupancy
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    any_valid  = 1'b0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (!flags_q[i][FL_VALID]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end else begin
        any_valid = 1'b1;
      end
    end
  end

  // pool size and overflow checks
  always_comb begin
    pool_sum  = (POOL_W'(init_pages_i) << page_shift_i) + POOL_W'(grown_q);
    ovf_size  = (pool_sum + POOL_W'(size)) > LIMIT32;
    ovf_delta = (pool_sum + POOL_W'(delta_q)) > LIMIT32;
  end

  assign hslot = SLOT_W'(hd_q);
  assign fit   = !flags_q[cur_slot_q][FL_ACTIVE] && ({2'b00, rdata.length} >= size);

  // sequencer
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    w_d        = w_q;
    h_d        = h_q;
    hd_d       = hd_q;
    cur_slot_d = cur_slot_q;
    cur_d      = cur_q;
    new_slot_d = new_slot_q;
    aux_slot_d = aux_slot_q;
    delta_d    = delta_q;
    app_off_d  = app_off_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    top_d      = top_q;
    grown_d    = grown_q;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      flags_d[i] = flags_q[i];
    end
    mreq       = '0;
    done_o     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        res_d = '0;
        if (start_i) begin
          mode_d  = mode_i;
          w_d     = width_i;
          h_d     = height_i;
          hd_d    = handle_i;
          state_d = (mode_i == MODE_ALLOC) ? S_MUL : S_CHK;
        end
      end
      S_MUL: state_d = S_RND;
      S_RND: state_d = S_ASTART;
      S_ASTART: begin
        if (|size[SIZE_W-1:32]) begin
          res_d.status = STAT_OVF;
          state_d      = S_OUT;
        end else if (!any_valid) begin
          state_d = S_EMPTY;
        end else begin
          mreq.raddr = top_q;
          cur_slot_d = top_q;
          cnt_d      = '0;
          state_d    = S_SRCH;
        end
      end
      // walk down from the top, one segment a cycle
      S_SRCH: begin
        cur_d = rdata;
        if (fit) begin
          if ({2'b00, rdata.length} == size) begin
            flags_d[cur_slot_q][FL_ACTIVE] = 1'b1;
            res_d.slot   = 4'(cur_slot_q);
            res_d.offset = rdata.offset;
            res_d.stride = {w_q, 2'b00};
            state_d      = S_OUT;
          end else begin
            state_d = S_SPLIT;
          end
        end else if (flags_q[cur_slot_q][FL_FIRST] ||
                     cnt_q == SLOT_W'(MAX_SEGMENTS - 1)) begin
          mreq.raddr = top_q;
          state_d    = S_NOFIT;
        end else begin
          mreq.raddr = rdata.lower;
          cur_slot_d = rdata.lower;
          cnt_d      = cnt_q + SLOT_W'(1);
        end
      end
      // split: new low part in a fresh slot
      S_SPLIT: begin
        if (!free_found) begin
          res_d.status = STAT_FULL;
          state_d      = S_OUT;
        end else begin
          mreq.we           = 1'b1;
          mreq.mask         = '{off: 1'b1, len: 1'b1, lo: 1'b1, hi: 1'b1};
          mreq.waddr        = free_idx;
          mreq.wdata.offset = cur_q.offset;
          mreq.wdata.length = size[31:0];
          mreq.wdata.lower  = cur_q.lower;
          mreq.wdata.higher = cur_slot_q;
          flags_d[free_idx] = '0;
          flags_d[free_idx][FL_VALID]  = 1'b1;
          flags_d[free_idx][FL_ACTIVE] = 1'b1;
          flags_d[free_idx][FL_FIRST]  = flags_q[cur_slot_q][FL_FIRST];
          new_slot_d = free_idx;
          state_d    = flags_q[cur_slot_q][FL_FIRST] ? S_SPLIT3 : S_SPLIT2;
        end
      end
      S_SPLIT2: begin
        mreq.we           = 1'b1;
        mreq.mask.hi      = 1'b1;
        mreq.waddr        = cur_q.lower;
        mreq.wdata.higher = new_slot_q;
        state_d           = S_SPLIT3;
      end
      S_SPLIT3: begin
        mreq.we           = 1'b1;
        mreq.mask         = '{off: 1'b1, len: 1'b1, lo: 1'b1, hi: 1'b0};
        mreq.waddr        = cur_slot_q;
        mreq.wdata.offset = cur_q.offset + size[31:0];
        mreq.wdata.length = cur_q.length - size[31:0];
        mreq.wdata.lower  = new_slot_q;
        flags_d[cur_slot_q][FL_FIRST] = 1'b0;
        res_d.slot   = 4'(new_slot_q);
        res_d.offset = cur_q.offset;
        res_d.stride = {w_q, 2'b00};
        state_d      = S_OUT;
      end
      // no fit: top segment data arrives
      S_NOFIT: begin
        cur_d      = rdata;
        cur_slot_d = top_q;
        delta_d    = size - {2'b00, rdata.length};
        app_off_d  = rdata.offset + rdata.length;
        state_d    = flags_q[top_q][FL_ACTIVE] ? S_APPEND : S_GROW;
      end
      S_GROW: begin
        if (ovf_delta) begin
          res_d.status = STAT_OVF;
          state_d      = S_OUT;
        end else begin
          grown_d           = grown_q + delta_q[31:0];
          mreq.we           = 1'b1;
          mreq.mask.len     = 1'b1;
          mreq.waddr        = cur_slot_q;
          mreq.wdata.length = size[31:0];
          flags_d[cur_slot_q][FL_ACTIVE] = 1'b1;
          res_d.slot    = 4'(cur_slot_q);
          res_d.offset  = cur_q.offset;
          res_d.stride  = {w_q, 2'b00};
          res_d.resized = 1'b1;
          state_d       = S_OUT;
        end
      end
      S_APPEND: begin
        if (!free_found) begin
          res_d.status = STAT_FULL;
          state_d      = S_OUT;
        end else if (ovf_size) begin
          res_d.status = STAT_OVF;
          state_d      = S_OUT;
        end else begin
          mreq.we           = 1'b1;
          mreq.mask         = '{off: 1'b1, len: 1'b1, lo: 1'b1, hi: 1'b1};
          mreq.waddr        = free_idx;
          mreq.wdata.offset = app_off_q;
          mreq.wdata.length = size[31:0];
          mreq.wdata.lower  = cur_slot_q;
          mreq.wdata.higher = '0;
          flags_d[free_idx] = '0;
          flags_d[free_idx][FL_VALID]  = 1'b1;
          flags_d[free_idx][FL_ACTIVE] = 1'b1;
          flags_d[free_idx][FL_LAST]   = 1'b1;
          flags_d[cur_slot_q][FL_LAST] = 1'b0;
          top_d      = free_idx;
          grown_d    = grown_q + size[31:0];
          new_slot_d = free_idx;
          state_d    = S_APP2;
        end
      end
      S_APP2: begin
        mreq.we           = 1'b1;
        mreq.mask.hi      = 1'b1;
        mreq.waddr        = cur_slot_q;
        mreq.wdata.higher = new_slot_q;
        res_d.slot    = 4'(new_slot_q);
        res_d.offset  = app_off_q;
        res_d.stride  = {w_q, 2'b00};
        res_d.resized = 1'b1;
        state_d       = S_OUT;
      end
      // empty table: first segment
      S_EMPTY: begin
        if (!free_found) begin
          res_d.status = STAT_FULL;
          state_d      = S_OUT;
        end else if (ovf_size) begin
          res_d.status = STAT_OVF;
          state_d      = S_OUT;
        end else begin
          mreq.we     = 1'b1;
          mreq.mask   = '{off: 1'b1, len: 1'b1, lo: 1'b1, hi: 1'b1};
          mreq.waddr  = free_idx;
          mreq.wdata  = '{offset: 32'd0, length: size[31:0], lower: '0, higher: '0};
          flags_d[free_idx] = '0;
          flags_d[free_idx][FL_VALID]  = 1'b1;
          flags_d[free_idx][FL_ACTIVE] = 1'b1;
          flags_d[free_idx][FL_FIRST]  = 1'b1;
          flags_d[free_idx][FL_LAST]   = 1'b1;
          top_d         = free_idx;
          grown_d       = grown_q + size[31:0];
          res_d.slot    = 4'(free_idx);
          res_d.stride  = {w_q, 2'b00};
          res_d.resized = 1'b1;
          state_d       = S_OUT;
        end
      end
      // free, release, attach
      S_CHK: begin
        if (!(32'(hd_q) < 32'(MAX_SEGMENTS)) ||
            !flags_q[hslot][FL_VALID] || !flags_q[hslot][FL_ACTIVE]) begin
          res_d.status = STAT_BADH;
          state_d      = S_OUT;
        end else begin
          res_d.slot = hd_q;
          cur_slot_d = hslot;
          state_d    = S_OUT;
          priority case (mode_q)
            MODE_FREE: begin
              if (flags_q[hslot][FL_BUSY]) begin
                flags_d[hslot][FL_KILL] = 1'b1;
                res_d.status            = STAT_DEFER;
              end else begin
                state_d = S_RS;
              end
            end
            MODE_RELEASE: begin
              flags_d[hslot][FL_BUSY] = 1'b0;
              if (flags_q[hslot][FL_KILL]) state_d = S_RS;
            end
            default: flags_d[hslot][FL_BUSY] = 1'b1;
          endcase
          if (state_d == S_RS) begin
            flags_d[hslot][FL_ACTIVE] = 1'b0;
            flags_d[hslot][FL_BUSY]   = 1'b0;
            flags_d[hslot][FL_KILL]   = 1'b0;
            mreq.raddr                = hslot;
          end
        end
      end
      // retire: own entry arrives, look at the higher neighbor
      S_RS: begin
        cur_d = rdata;
        if (!flags_q[cur_slot_q][FL_LAST] && !flags_q[rdata.higher][FL_ACTIVE]) begin
          mreq.raddr = rdata.higher;
          state_d    = S_RH;
        end else begin
          state_d = S_RL0;
        end
      end
      S_RH: begin
        mreq.we           = 1'b1;
        mreq.waddr        = cur_slot_q;
        mreq.mask.len     = 1'b1;
        mreq.wdata.length = cur_q.length + rdata.length;
        cur_d.length      = cur_q.length + rdata.length;
        flags_d[cur_q.higher] = '0;
        if (flags_q[cur_q.higher][FL_LAST]) begin
          flags_d[cur_slot_q][FL_LAST] = 1'b1;
          top_d   = cur_slot_q;
          state_d = S_RL0;
        end else begin
          mreq.mask.hi      = 1'b1;
          mreq.wdata.higher = rdata.higher;
          cur_d.higher      = rdata.higher;
          aux_slot_d        = rdata.higher;
          state_d           = S_RH2;
        end
      end
      S_RH2: begin
        mreq.we          = 1'b1;
        mreq.mask.lo     = 1'b1;
        mreq.waddr       = aux_slot_q;
        mreq.wdata.lower = cur_slot_q;
        state_d          = S_RL0;
      end
      S_RL0: begin
        if (!flags_q[cur_slot_q][FL_FIRST] && !flags_q[cur_q.lower][FL_ACTIVE]) begin
          mreq.raddr = cur_q.lower;
          state_d    = S_RL;
        end else begin
          res_d.slot = 4'(cur_slot_q);
          state_d    = S_OUT;
        end
      end
      // merge into the lower neighbor
      S_RL: begin
        mreq.we           = 1'b1;
        mreq.waddr        = cur_q.lower;
        mreq.mask.len     = 1'b1;
        mreq.wdata.length = rdata.length + cur_q.length;
        flags_d[cur_slot_q] = '0;
        res_d.slot          = 4'(cur_q.lower);
        if (flags_q[cur_slot_q][FL_LAST]) begin
          flags_d[cur_q.lower][FL_LAST] = 1'b1;
          top_d   = cur_q.lower;
          state_d = S_OUT;
        end else begin
          mreq.mask.hi      = 1'b1;
          mreq.wdata.higher = cur_q.higher;
          state_d           = S_RL2;
        end
      end
      S_RL2: begin
        mreq.we          = 1'b1;
        mreq.mask.lo     = 1'b1;
        mreq.waddr       = cur_q.higher;
        mreq.wdata.lower = cur_q.lower;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result with pool size after the step
  always_comb begin
    res_o      = res_q;
    res_o.pool = (|pool_sum[POOL_W-1:32]) ? 32'hFFFF_FFFF : pool_sum[31:0];
  end

  assign idle_o = (state_q == S_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      grown_q <= '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        flags_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      grown_q <= grown_d;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        flags_q[i] <= flags_d[i];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    w_q        <= w_d;
    h_q        <= h_d;
    hd_q       <= hd_d;
    cur_slot_q <= cur_slot_d;
    cur_q      <= cur_d;
    new_slot_q <= new_slot_d;
    aux_slot_q <= aux_slot_d;
    delta_q    <= delta_d;
    app_off_q  <= app_off_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
  end

endmodule

// ----- hw/rtl/first_fit_segment_allocator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_segment_allocator
// Growable pool of contiguous segments with first-fit allocation,
// splitting, coalescing free and deferred free of busy segments.
// ---------------------------------------------------------------------------
//  channel  valid        stall        payload
//  in       in_valid_i   in_stall_o   mode_i width_i height_i handle_i
//  out      out_valid_o  out_stall_i  status_o slot_o byte_offset_o
//                                     row_stride_o pool_bytes_o pool_resized_o
//  cfg      cfg_we_i     -            cfg_index_i cfg_data_i
//
// One word at a time. Allocate walks up to 16 segments on the first-fit
// search and then updates the segment table. The table memory, with a single
// write port and a single registered read port, sets the pace.
// Reset clears all segment flags; no clearing pass is needed.
// The next word is taken while a result waits in the output register.
// ---------------------------------------------------------------------------
module first_fit_segment_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [14:0] width_i,
  input  logic [14:0] height_i,
  input  logic [3:0]  handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [31:0] byte_offset_o,
  output logic [16:0] row_stride_o,
  output logic [31:0] pool_bytes_o,
  output logic        pool_resized_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i
);
  import fseg_pkg::*;

  logic [4:0]  page_shift_q;
  logic [20:0] init_pages_q;
  logic        out_valid_q;
  res_t        out_q;
  logic        idle;
  logic        done;
  logic        out_free;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= 5'd12;
      init_pages_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAGE_SHIFT: page_shift_q <= cfg_data_i[4:0];
        CFG_INIT_PAGES: init_pages_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  fseg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i && idle),
    .mode_i       (mode_i),
    .width_i      (width_i),
    .height_i     (height_i),
    .handle_i     (handle_i),
    .page_shift_i (page_shift_q),
    .init_pages_i (init_pages_q),
    .out_free_i   (out_free),
    .idle_o       (idle),
    .done_o       (done),
    .res_o        (res)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign slot_o         = out_q.slot;
  assign byte_offset_o  = out_q.offset;
  assign row_stride_o   = out_q.stride;
  assign pool_bytes_o   = out_q.pool;
  assign pool_resized_o = out_q.resized;

endmodule

// ----- dv/first_fit_segment_allocator_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_segment_allocator_test
// Drives allocate, free, release and attach words into the allocator, keeps
// its own copy of the segment table to predict every result word, and
// compares each result field by field under random idling on both channels.
// ---------------------------------------------------------------------------
module first_fit_segment_allocator_test;
  import fseg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = MODE_ALLOC;
  logic [14:0] width_i = 15'd1;
  logic [14:0] height_i = 15'd1;
  logic [3:0]  handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  slot_o;
  logic [31:0] byte_offset_o;
  logic [16:0] row_stride_o;
  logic [31:0] pool_bytes_o;
  logic        pool_resized_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_PAGE_SHIFT;
  logic [20:0] cfg_data_i = '0;

  first_fit_segment_allocator uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model of the segment table
  logic [4:0]  m_shift;
  logic [20:0] m_init_pages;
  logic [31:0] m_off [MAX_SEGMENTS];
  logic [31:0] m_len [MAX_SEGMENTS];
  flags_t      m_fl  [MAX_SEGMENTS];
  logic [3:0]  m_lo  [MAX_SEGMENTS];
  logic [3:0]  m_hi  [MAX_SEGMENTS];
  logic [3:0]  m_top;
  logic [31:0] m_grown;

  res_t expected_words[$];
  int   errors = 0;
  int   long_hold = 0;
  bit   quiet_out = 0;

  function automatic logic [63:0] base_bytes();
    return 64'(m_init_pages) << m_shift;
  endfunction

  function automatic bit grows_past(logic [63:0] extra);
    return base_bytes() + 64'(m_grown) + extra > 64'hFFFF_FFFF;
  endfunction

  function automatic int first_unused();
    for (int i = 0; i < MAX_SEGMENTS; i++)
      if (!m_fl[i][FL_VALID]) return i;
    return -1;
  endfunction

  // free a segment and merge with free neighbors
  function automatic logic [3:0] retire_seg(logic [3:0] s);
    logic [3:0] h, l;
    m_fl[s][FL_ACTIVE] = 0; m_fl[s][FL_BUSY] = 0; m_fl[s][FL_KILL] = 0;
    if (!m_fl[s][FL_LAST]) begin
      h = m_hi[s];
      if (!m_fl[h][FL_ACTIVE]) begin
        m_len[s] += m_len[h];
        if (m_fl[h][FL_LAST]) begin
          m_fl[s][FL_LAST] = 1; m_top = s;
        end else begin
          m_hi[s] = m_hi[h]; m_lo[m_hi[h]] = s;
        end
        m_fl[h] = '0;
      end
    end
    if (!m_fl[s][FL_FIRST]) begin
      l = m_lo[s];
      if (!m_fl[l][FL_ACTIVE]) begin
        m_len[l] += m_len[s];
        if (m_fl[s][FL_LAST]) begin
          m_fl[l][FL_LAST] = 1; m_top = l;
        end else begin
          m_hi[l] = m_hi[s]; m_lo[m_hi[s]] = l;
        end
        m_fl[s] = '0;
        return l;
      end
    end
    return s;
  endfunction

  function automatic void alloc_seg(logic [14:0] w, logic [14:0] h, ref res_t r);
    logic [63:0] page, size, delta;
    logic [3:0] s;
    bit found, any;
    int n;
    page = 64'd1 << m_shift;
    size = 64'd4 * w * h;
    size = ((size + page - 1) >> m_shift) << m_shift;
    if (size == 0) size = page;
    if (size > 64'hFFFF_FFFF) begin r.status = STAT_OVF; return; end
    any = 0;
    found = 0;
    for (int i = 0; i < MAX_SEGMENTS; i++) if (m_fl[i][FL_VALID]) any = 1;
    if (any) begin
      s = m_top;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (!m_fl[s][FL_ACTIVE] && 64'(m_len[s]) >= size) begin found = 1; break; end
        if (m_fl[s][FL_FIRST]) break;
        s = m_lo[s];
      end
      if (found) begin
        if (64'(m_len[s]) == size) begin
          m_fl[s][FL_ACTIVE] = 1; r.slot = s; r.offset = m_off[s];
        end else begin
          n = first_unused();
          if (n < 0) begin r.status = STAT_FULL; return; end
          m_off[n] = m_off[s]; m_len[n] = size[31:0];
          m_fl[n] = '0;
          m_fl[n][FL_VALID] = 1; m_fl[n][FL_ACTIVE] = 1;
          m_fl[n][FL_FIRST] = m_fl[s][FL_FIRST];
          m_hi[n] = s; m_lo[n] = m_lo[s];
          if (!m_fl[s][FL_FIRST]) m_hi[m_lo[s]] = 4'(n);
          m_lo[s] = 4'(n);
          m_fl[s][FL_FIRST] = 0;
          m_off[s] += size[31:0]; m_len[s] -= size[31:0];
          r.slot = 4'(n); r.offset = m_off[n];
        end
        r.stride = 17'(4 * w);
        return;
      end
      s = m_top;
      if (!m_fl[s][FL_ACTIVE]) begin
        delta = size - 64'(m_len[s]);
        if (grows_past(delta)) begin r.status = STAT_OVF; return; end
        m_grown += delta[31:0]; m_len[s] = size[31:0]; m_fl[s][FL_ACTIVE] = 1;
        r.slot = s; r.offset = m_off[s];
      end else begin
        n = first_unused();
        if (n < 0) begin r.status = STAT_FULL; return; end
        if (grows_past(size)) begin r.status = STAT_OVF; return; end
        m_off[n] = m_off[s] + m_len[s]; m_len[n] = size[31:0];
        m_fl[n] = '0;
        m_fl[n][FL_VALID] = 1; m_fl[n][FL_ACTIVE] = 1; m_fl[n][FL_LAST] = 1;
        m_lo[n] = s; m_hi[n] = 0; m_hi[s] = 4'(n);
        m_fl[s][FL_LAST] = 0; m_top = 4'(n); m_grown += size[31:0];
        r.slot = 4'(n); r.offset = m_off[n];
      end
    end else begin
      n = first_unused();
      if (n < 0) begin r.status = STAT_FULL; return; end
      if (grows_past(size)) begin r.status = STAT_OVF; return; end
      m_off[n] = 0; m_len[n] = size[31:0];
      m_fl[n] = '0;
      m_fl[n][FL_VALID] = 1; m_fl[n][FL_ACTIVE] = 1;
      m_fl[n][FL_FIRST] = 1; m_fl[n][FL_LAST] = 1;
      m_lo[n] = 0; m_hi[n] = 0; m_top = 4'(n); m_grown += size[31:0];
      r.slot = 4'(n); r.offset = '0;
    end
    r.stride = 17'(4 * w);
    r.resized = 1;
  endfunction

  function automatic res_t predict_word(logic [1:0] md, logic [14:0] w,
                                        logic [14:0] h, logic [3:0] hd);
    res_t r;
    logic [63:0] t;
    r = '0;
    r.status = STAT_OK;
    if (md == MODE_ALLOC) begin
      alloc_seg(w, h, r);
    end else if (!(m_fl[hd][FL_VALID] && m_fl[hd][FL_ACTIVE])) begin
      r.status = STAT_BADH;
    end else begin
      r.slot = hd;
      if (md == MODE_FREE) begin
        if (m_fl[hd][FL_BUSY]) begin
          m_fl[hd][FL_KILL] = 1; r.status = STAT_DEFER;
        end else begin
          r.slot = retire_seg(hd);
        end
      end else if (md == MODE_RELEASE) begin
        m_fl[hd][FL_BUSY] = 0;
        if (m_fl[hd][FL_KILL]) r.slot = retire_seg(hd);
      end else begin
        m_fl[hd][FL_BUSY] = 1;
      end
    end
    t = base_bytes() + 64'(m_grown);
    r.pool = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    return r;
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // send one request word and queue its prediction; valid stays high after
  // the accept so a word with no gap follows at once
  task automatic send_word(logic [1:0] md, logic [14:0] w, logic [14:0] h,
                           logic [3:0] hd, bit gaps = 1);
    int g;
    g = gaps ? short_or_long_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md; width_i <= w; height_i <= h; handle_i <= hd;
    do @(posedge clk_i); while (in_stall_o);
    expected_words.push_back(predict_word(md, w, h, hd));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PAGE_SHIFT) m_shift = val[4:0];
    else m_init_pages = val;
    @(posedge clk_i);
  endtask

  // receiver stall: random gaps, plus a long hold when requested
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      out_stall_i <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (quiet_out) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word status %0d", $realtime, status_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (status_o !== e.status || slot_o !== e.slot || byte_offset_o !== e.offset ||
            row_stride_o !== e.stride || pool_bytes_o !== e.pool ||
            pool_resized_o !== e.resized) begin
          $display("%0t: mismatch expected st=%0d sl=%0d off=%h str=%0d pool=%h rs=%0d",
                   $realtime, e.status, e.slot, e.offset, e.stride, e.pool, e.resized);
          $display("%0t:          actual   st=%0d sl=%0d off=%h str=%0d pool=%h rs=%0d",
                   $realtime, status_o, slot_o, byte_offset_o, row_stride_o,
                   pool_bytes_o, pool_resized_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [3:0] pick_handle();
    int c;
    logic [3:0] hs [$];
    for (int i = 0; i < MAX_SEGMENTS; i++)
      if (m_fl[i][FL_VALID] && m_fl[i][FL_ACTIVE]) hs.push_back(4'(i));
    if (hs.size() == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    c = $urandom_range(0, hs.size() - 1);
    return hs[c];
  endfunction

  function automatic logic [14:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 15'($urandom);
      1: return 15'd16384;
      2: return 15'($urandom_range(0, 1));
      default: return 15'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic test_directed();
    send_word(MODE_FREE, 15'd1, 15'd1, 4'd0);
    send_word(MODE_ALLOC, 15'd0, 15'd5, 4'd0);
    send_word(MODE_ALLOC, 15'd16384, 15'd16384, 4'd0);
    send_word(MODE_ALLOC, 15'h7FFF, 15'h7FFF, 4'hF);
    send_word(MODE_ALLOC, 15'd1024, 15'd2, 4'd0);
    send_word(MODE_ATTACH, 15'd1, 15'd1, 4'd1);
    send_word(MODE_FREE, 15'd1, 15'd1, 4'd1);
    send_word(MODE_FREE, 15'd1, 15'd1, 4'd1);
    send_word(MODE_RELEASE, 15'd1, 15'd1, 4'd1);
    send_word(MODE_RELEASE, 15'd1, 15'd1, 4'd0);
    send_word(MODE_FREE, 15'd1, 15'd1, 4'd0);
    send_word(MODE_ALLOC, 15'd1, 15'd1, 4'd0);
    send_word(MODE_ALLOC, 15'd1, 15'd1, 4'd0);
    send_word(MODE_ATTACH, 15'd1, 15'd1, 4'hF);
    // fill the table to reach table full
    for (int i = 0; i < 17; i++) send_word(MODE_ALLOC, 15'd1, 15'd1, 4'd0, 0);
    drain_results();
  endtask

  task automatic test_backpressure();
    long_hold = 300;
    for (int i = 0; i < 30; i++)
      send_word(2'($urandom_range(0, 3)), rand_dim(), rand_dim(), pick_handle(), 0);
    drain_results();
  endtask

  task automatic test_random(int count);
    logic [1:0] md;
    for (int i = 0; i < count; i++) begin
      md = ($urandom_range(0, 9) < 4) ? MODE_ALLOC : 2'($urandom_range(1, 3));
      quiet_out = ($urandom_range(0, 7) == 0);
      send_word(md, rand_dim(), rand_dim(), pick_handle());
    end
    quiet_out = 0;
    drain_results();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_PAGE_SHIFT, 21'd0);
    write_reg(CFG_INIT_PAGES, 21'd0);
    test_random(300);
    write_reg(CFG_PAGE_SHIFT, 21'd16);
    write_reg(CFG_INIT_PAGES, 21'h1FFFFF);
    test_random(300);
    write_reg(CFG_PAGE_SHIFT, 21'($urandom_range(0, 31)));
    write_reg(CFG_INIT_PAGES, 21'd1048576);
    test_random(300);
    write_reg(CFG_PAGE_SHIFT, 21'd12);
    write_reg(CFG_INIT_PAGES, 21'($urandom_range(0, 4096)));
    test_random(400);
  endtask

  initial begin
    m_shift = 5'd12; m_init_pages = '0; m_top = '0; m_grown = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      m_off[i] = '0; m_len[i] = '0; m_fl[i] = '0; m_lo[i] = '0; m_hi[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(200);
    test_config_sweep();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("first_fit_segment_allocator test passed");
    end else begin
      $display("first_fit_segment_allocator test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("first_fit_segment_allocator test failed");
    $finish;
  end

endmodule
